// ===== rtl/pip_pkg.sv =====
`timescale 1ns / 1ps

package pip_pkg;

  // Vertex store geometry.
  localparam int MAX_VERTICES = 1024;
  localparam int AW           = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  // Fixed field widths.
  localparam int IDX_W   = 10;
  localparam int COORD_W = 32;
  localparam int CFG_W   = 11;
  localparam int VERD_W  = 2;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Verdict codes.
  localparam logic [VERD_W-1:0] VERDICT_OUTSIDE = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_INSIDE  = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_BORDER  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          load_we;   // write the incoming vertex into the store
    logic          start;     // latch the query point and clear the accumulators
    logic          issue;     // one walk step enters the edge pipeline
    logic          first;     // the step reads vertex 0, no edge yet
    logic          wrap;      // the step closes the polygon with vertex 0
    logic [AW-1:0] rd_addr;   // store address read by the step
    logic          out_load;  // capture the verdict into the output register
  } pip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;               // edges still in flight in the pipeline
  } pip_sts_t;

endpackage

// ===== rtl/pip_ifs.sv =====
`timescale 1ns / 1ps

interface pip_req_if import pip_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [IDX_W-1:0]          vertex_index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  modport source (output valid, req_type, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, req_type, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_res_if import pip_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERD_W-1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

interface pip_cfg_if import pip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/pip_datapath.sv =====
`timescale 1ns / 1ps

module pip_datapath import pip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pip_cmd_t                  cmd,
  output pip_sts_t                  sts,
  input  logic [IDX_W-1:0]          wr_index,
  input  logic signed [COORD_W-1:0] pt_x,
  input  logic signed [COORD_W-1:0] pt_y,
  output logic [VERD_W-1:0]         verdict
);

  localparam int DW = COORD_W + 1;
  localparam int PW = 2 * DW;

  // Lexicographic a <= b, x first, then y.
  function automatic logic lex_le(input logic signed [COORD_W-1:0] ax,
                                  input logic signed [COORD_W-1:0] ay,
                                  input logic signed [COORD_W-1:0] bx,
                                  input logic signed [COORD_W-1:0] by);
    return (ax < bx) || ((ax == bx) && (ay <= by));
  endfunction

  logic [2*COORD_W-1:0] mem [MAX_VERTICES];
  logic [2*COORD_W-1:0] mem_q_r;

  logic signed [COORD_W-1:0] px_r, py_r;
  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic va_r, a_first_r, a_wrap_r;
  logic vb_r, vc_r;
  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r;
  logic seg_b_r, up_b_r, dn_b_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic seg_c_r, up_c_r, dn_c_r;
  logic border_r, parity_r;
  logic [VERD_W-1:0] verdict_r;

  logic wr_ok;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic i_le_j, on_seg, i_ge, j_ge;
  logic signed [PW:0] cross_d;
  logic s_pos, s_neg, s_zero;

  assign wr_ok = (32'(wr_index) < MAX_VERTICES);

  // Store: one write port for loads, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (cmd.load_we && wr_ok) begin
      mem[wr_index[AW-1:0]] <= {pt_x, pt_y};
    end
    if (cmd.issue && !cmd.wrap) begin
      mem_q_r <= mem[cmd.rd_addr];
    end
  end

  // Stage A: the current vertex is the store word, or vertex 0 when closing.
  always_comb begin
    cur_x  = a_wrap_r ? first_x_r : mem_q_r[2*COORD_W-1:COORD_W];
    cur_y  = a_wrap_r ? first_y_r : mem_q_r[COORD_W-1:0];
    i_le_j = lex_le(prev_x_r, prev_y_r, cur_x, cur_y);
    on_seg = i_le_j ?
             (lex_le(prev_x_r, prev_y_r, px_r, py_r) && lex_le(px_r, py_r, cur_x, cur_y)) :
             (lex_le(cur_x, cur_y, px_r, py_r) && lex_le(px_r, py_r, prev_x_r, prev_y_r));
    i_ge   = (prev_y_r >= py_r);
    j_ge   = (cur_y >= py_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= pt_x;
      py_r <= pt_y;
    end
    if (va_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
      if (a_first_r) begin
        first_x_r <= cur_x;
        first_y_r <= cur_y;
      end
    end
    a_first_r <= cmd.first;
    a_wrap_r  <= cmd.wrap;
    // Stage B: edge endpoints relative to the point.
    dax_r   <= DW'(prev_x_r) - DW'(px_r);
    day_r   <= DW'(prev_y_r) - DW'(py_r);
    dbx_r   <= DW'(cur_x) - DW'(px_r);
    dby_r   <= DW'(cur_y) - DW'(py_r);
    seg_b_r <= on_seg;
    up_b_r  <= j_ge && !i_ge;
    dn_b_r  <= i_ge && !j_ge;
    // Stage C: the two products of the cross product.
    p1_r    <= PW'(dax_r) * PW'(dby_r);
    p2_r    <= PW'(day_r) * PW'(dbx_r);
    seg_c_r <= seg_b_r;
    up_c_r  <= up_b_r;
    dn_c_r  <= dn_b_r;
    if (cmd.out_load) begin
      verdict_r <= border_r ? VERDICT_BORDER :
                   (parity_r ? VERDICT_INSIDE : VERDICT_OUTSIDE);
    end
  end

  // Stage D: sign of the cross product decides border and crossings.
  always_comb begin
    cross_d = (PW+1)'(p1_r) - (PW+1)'(p2_r);
    s_zero  = (cross_d == '0);
    s_neg   = cross_d[PW];
    s_pos   = !s_neg && !s_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
      vc_r     <= 1'b0;
      border_r <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      va_r <= cmd.issue;
      vb_r <= va_r && !a_first_r;
      vc_r <= vb_r;
      if (cmd.start) begin
        border_r <= 1'b0;
        parity_r <= 1'b0;
      end else if (vc_r) begin
        if (s_zero && seg_c_r) begin
          border_r <= 1'b1;
        end
        if ((up_c_r && s_pos) || (dn_c_r && s_neg)) begin
          parity_r <= !parity_r;
        end
      end
    end
  end

  assign sts.busy = va_r || vb_r || vc_r;
  assign verdict  = verdict_r;

endmodule

// ===== rtl/pip_ctrl.sv =====
`timescale 1ns / 1ps

module pip_ctrl import pip_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output pip_cmd_t         cmd,
  input  pip_sts_t         sts
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CFG_W-1:0] vcount_r, vcount_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] n_eff;

  assign n_eff = (32'(vcount_r) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vcount_r);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    vcount_nxt    = (cfg_valid && cfg_ready) ? cfg_data : vcount_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.rd_addr   = k_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.start = 1'b1;
            n_nxt     = n_eff;
            k_nxt     = '0;
            state_nxt = (n_eff == '0) ? S_DRAIN : S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.issue = 1'b1;
        if (k_r != n_r) begin
          cmd.first = (k_r == '0);
          k_nxt     = k_r + CNT_W'(1);
        end else begin
          cmd.wrap  = 1'b1;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      n_r         <= '0;
      vcount_r    <= CFG_W'(3);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // The walk counter never runs past the closing step.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> k_r <= n_r)
    else $error("walk counter passed the vertex count");

  // A verdict is only captured once every edge has left the pipeline.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.busy)
    else $error("verdict captured while edges in flight");

  // A pending result that is not taken is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !cmd.out_load)
    else $error("pending result overwritten");

  // No step enters the pipeline outside the walk.
  a_issue_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> state_r == S_WALK && !in_ready)
    else $error("pipeline step issued outside the walk");

endmodule

// ===== rtl/point_in_polygon_test.sv =====
`timescale 1ns / 1ps

// Point-in-polygon test by ray crossing. Load words write one polygon vertex
// (x, y) into slot vertex_index of a 1024-entry store and give no result.
// A query word carries a point; the block walks every edge from vertex i to
// vertex (i+1) mod n, n being vertex_count saturated at 1024, and returns one
// verdict word: 0 outside, 1 inside, 2 on the border. For a query, the walk
// reads the store's single read port once per vertex, plus one closing step;
// then a four-stage edge pipeline (read, difference, multiply, sign) drains
// before the verdict is captured. Queries that read a slot never loaded since
// reset give an undefined verdict.
// The vertex_count register is written through the cfg_wr channel, which is
// always ready; write it only while no query is in progress. A finished
// verdict sits in an output register, so the next word is accepted while it
// waits to be taken.

module point_in_polygon_test import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pip_req_if.sink   in_req,
  pip_res_if.source out_res,
  pip_cfg_if.sink   cfg_wr
);

  pip_cmd_t cmd;
  pip_sts_t sts;

  // The sequencer owns the handshakes, the vertex count and the walk counter.
  pip_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_req_type (in_req.req_type),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .cfg_valid   (cfg_wr.valid),
    .cfg_ready   (cfg_wr.ready),
    .cfg_data    (cfg_wr.data),
    .cmd         (cmd),
    .sts         (sts)
  );

  // The datapath holds the vertex store, the query point and the edge pipeline.
  pip_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .wr_index (in_req.vertex_index),
    .pt_x     (in_req.coord_x),
    .pt_y     (in_req.coord_y),
    .verdict  (out_res.verdict)
  );

endmodule
